FILE: hw/rtl/lbp_pkg.sv
// Shared types, sizes and helpers for the 3x3 LBP code stream.
// No dependencies; every file that uses this package refers to it by scoped names.
package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int CFGW_W     = 11;               // frame_width register
  localparam int CFGH_W     = 13;               // frame_height register
  localparam int HT_W       = ROW_W + 1;
  localparam int CW_W       = (COL_W + 1 > CFGW_W) ? COL_W + 1 : CFGW_W;
  localparam int CFG_DATA_W = (CFGW_W > CFGH_W) ? CFGW_W : CFGH_W;
  localparam int CFG_IDX_W  = 2;
  localparam int PIX_W      = 8;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFGW_W-1:0] WIDTH_RESET  = CFGW_W'(640);
  localparam logic [CFGH_W-1:0] HEIGHT_RESET = CFGH_W'(480);

  // position of the request being accepted
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             emit;
    logic             last;
  } pos_t;

  // request held in the read stage
  typedef struct packed {
    logic             emit;
    logic             last;
    logic [PIX_W-1:0] px;
  } item_t;

  function automatic logic [CW_W-1:0] eff_width(input logic [CFGW_W-1:0] w);
    logic [CW_W-1:0] e;
    e = CW_W'(w);
    if (e < CW_W'(3)) e = CW_W'(3);
    if (e > CW_W'(MAX_WIDTH)) e = CW_W'(MAX_WIDTH);
    return e;
  endfunction

  function automatic logic [HT_W-1:0] eff_height(input logic [CFGH_W-1:0] h);
    logic [CFGH_W-1:0] e;
    e = h;
    if (e < CFGH_W'(3)) e = CFGH_W'(3);
    if (e > CFGH_W'(MAX_HEIGHT)) e = CFGH_W'(MAX_HEIGHT);
    return e[HT_W-1:0];
  endfunction

endpackage

FILE: hw/rtl/lbp_if.sv
// Stream interfaces for pixel requests in and code requests out.
// Depends on lbp_pkg for field widths.
interface lbp_pix_if;
  logic                       valid;
  logic                       ready;
  logic [lbp_pkg::PIX_W-1:0]  pixel;
  logic                       start_frame;
  modport source (output valid, output pixel, output start_frame, input ready);
  modport sink   (input valid, input pixel, input start_frame, output ready);
endinterface

interface lbp_code_if;
  logic                       valid;
  logic                       ready;
  logic [lbp_pkg::PIX_W-1:0]  lbp_code;
  logic                       last_code;
  modport source (output valid, output lbp_code, output last_code, input ready);
  modport sink   (input valid, input lbp_code, input last_code, output ready);
endinterface

FILE: hw/rtl/lbp_line_ram.sv
// Simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lbp_line_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/lbp_position.sv
// Column/row tracker: places each accepted pixel in the frame.
// Depends on lbp_pkg.
module lbp_position (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic                        start_frame_i,
  input  logic [lbp_pkg::CW_W-1:0]    width_i,
  input  logic [lbp_pkg::HT_W-1:0]    height_i,
  output lbp_pkg::pos_t               pos_o
);

  logic [lbp_pkg::COL_W-1:0] column_count_q, column_count_d;
  logic [lbp_pkg::ROW_W-1:0] row_count_q, row_count_d;
  logic [lbp_pkg::COL_W-1:0] col;
  logic [lbp_pkg::ROW_W-1:0] row;
  logic [lbp_pkg::HT_W-1:0]  rc;
  logic [lbp_pkg::CW_W-1:0]  col_inc;
  logic [lbp_pkg::HT_W-1:0]  row_inc;

  always_comb begin
    col = column_count_q;
    rc  = lbp_pkg::HT_W'(row_count_q);
    // width shrunk under us: end the row
    if (lbp_pkg::CW_W'(column_count_q) >= width_i) begin
      col = '0;
      rc  = rc + lbp_pkg::HT_W'(1);
    end
    if (rc >= height_i) rc = '0;
    if (start_frame_i) begin
      col = '0;
      rc  = '0;
    end
    row = rc[lbp_pkg::ROW_W-1:0];

    pos_o.col  = col;
    pos_o.emit = (row >= lbp_pkg::ROW_W'(2)) && (col >= lbp_pkg::COL_W'(2));
    pos_o.last = (lbp_pkg::HT_W'(row) == height_i - lbp_pkg::HT_W'(1)) &&
                 (lbp_pkg::CW_W'(col) == width_i - lbp_pkg::CW_W'(1));

    col_inc = lbp_pkg::CW_W'(col) + lbp_pkg::CW_W'(1);
    row_inc = lbp_pkg::HT_W'(row) + lbp_pkg::HT_W'(1);
    if (col_inc >= width_i) begin
      column_count_d = '0;
      row_count_d    = (row_inc >= height_i) ? '0 : row_inc[lbp_pkg::ROW_W-1:0];
    end else begin
      column_count_d = col_inc[lbp_pkg::COL_W-1:0];
      row_count_d    = row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_count_q <= '0;
      row_count_q    <= '0;
    end else if (accept_i) begin
      column_count_q <= column_count_d;
      row_count_q    <= row_count_d;
    end
  end

endmodule

FILE: hw/rtl/lbp_window.sv
// 3x3 window shift and code compare, with the output register.
// Depends on lbp_pkg and lbp_code_if.
module lbp_window (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  lbp_pkg::item_t             item_i,
  input  logic [lbp_pkg::PIX_W-1:0]  top_i,
  input  logic [lbp_pkg::PIX_W-1:0]  mid_i,
  output logic                       room_o,
  lbp_code_if.source                 code_o
);

  // 0..2: column col-2 top/mid/bot, 3..5: column col-1
  logic [lbp_pkg::PIX_W-1:0] window_q [6];
  logic [lbp_pkg::PIX_W-1:0] c;
  logic [lbp_pkg::PIX_W-1:0] code_d, code_q;
  logic                      last_q;
  logic                      valid_q;

  assign c = window_q[4];

  always_comb begin
    code_d[7] = window_q[0] > c;
    code_d[6] = window_q[3] > c;
    code_d[5] = top_i > c;
    code_d[4] = mid_i > c;
    code_d[3] = item_i.px > c;
    code_d[2] = window_q[5] > c;
    code_d[1] = window_q[2] > c;
    code_d[0] = window_q[1] > c;
  end

  assign room_o = !valid_q || code_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 6; i++) window_q[i] <= '0;
      valid_q <= 1'b0;
    end else begin
      if (step_i) begin
        window_q[0] <= window_q[3];
        window_q[1] <= window_q[4];
        window_q[2] <= window_q[5];
        window_q[3] <= top_i;
        window_q[4] <= mid_i;
        window_q[5] <= item_i.px;
      end
      if (step_i && item_i.emit) begin
        valid_q <= 1'b1;
      end else if (code_o.ready) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_i && item_i.emit) begin
      code_q <= code_d;
      last_q <= item_i.last;
    end
  end

  assign code_o.valid     = valid_q;
  assign code_o.lbp_code  = code_q;
  assign code_o.last_code = last_q;

endmodule

FILE: hw/rtl/lbp_texture_code_stream.sv
// Top level of the streaming 3x3 local binary pattern coder.
// Depends on lbp_pkg, lbp_if, lbp_line_ram, lbp_position and lbp_window.
//
// Usage:
//   pix_i carries grey pixels in raster order; start_frame marks the first
//   pixel of a frame (a frame also wraps by itself after its last pixel).
//   code_o carries one 8-bit pattern code per interior pixel, in raster
//   order; last_code flags the final interior code of the frame. Border
//   pixels produce no code.
//   Config: cfg_we_i writes cfg_data_i to register cfg_idx_i (0 frame_width,
//   1 frame_height). Write only while the block is idle.
// Timing:
//   One pixel per clock sustained while code_o is not stalled. Each
//   accepted pixel request loads the read stage and starts the line buffer
//   read (one RAM for both rows, written as the pixel leaves the read
//   stage); when the read stage advances, the compare goes to the output register.
// Reset: position, window and valid flags clear; registers go to 640x480.
//   Line buffers are not cleared: unwritten entries only feed pixels that produce no code.
// Backpressure:
//   While code_o is stalled the output register and the read stage hold,
//   and pix_i.ready stays high only while the read stage has room.
module lbp_texture_code_stream (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [lbp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  lbp_pix_if.sink                          pix_i,
  lbp_code_if.source                       code_o
);

  logic [lbp_pkg::CFGW_W-1:0] frame_width_q;
  logic [lbp_pkg::CFGH_W-1:0] frame_height_q;
  logic [lbp_pkg::CW_W-1:0]   eff_w;
  logic [lbp_pkg::HT_W-1:0]   eff_h;

  lbp_pkg::pos_t              pos;
  logic                       accept;
  logic                       room;
  logic                       s1_adv;

  // read stage
  logic                       s1_valid_q;
  lbp_pkg::item_t             s1_item_q;
  logic [lbp_pkg::COL_W-1:0]  s1_col_q;
  logic                       fwd_q;
  logic [2*lbp_pkg::PIX_W-1:0] fwd_data_q;
  logic [2*lbp_pkg::PIX_W-1:0] rdata;
  logic [lbp_pkg::PIX_W-1:0]  top, mid;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= lbp_pkg::WIDTH_RESET;
      frame_height_q <= lbp_pkg::HEIGHT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lbp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_data_i[lbp_pkg::CFGW_W-1:0];
        lbp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_data_i[lbp_pkg::CFGH_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_w = lbp_pkg::eff_width(frame_width_q);
  assign eff_h = lbp_pkg::eff_height(frame_height_q);

  // the read stage moves on whenever the output register can take it
  assign s1_adv      = s1_valid_q && room;
  assign pix_i.ready = !s1_valid_q || room;
  assign accept      = pix_i.valid && pix_i.ready;

  lbp_position u_pos (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .start_frame_i (pix_i.start_frame),
    .width_i       (eff_w),
    .height_i      (eff_h),
    .pos_o         (pos)
  );

  // line buffers as one RAM word: {older, newer}
  lbp_line_ram #(
    .DEPTH (lbp_pkg::MAX_WIDTH),
    .WIDTH (2*lbp_pkg::PIX_W)
  ) u_lines (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_col_q),
    .wdata_i ({mid, s1_item_q.px}),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (rdata)
  );

  // a restart can read the column being written in the same cycle;
  // take the write data instead of the stale RAM word
  assign top = fwd_q ? fwd_data_q[2*lbp_pkg::PIX_W-1:lbp_pkg::PIX_W]
                     : rdata[2*lbp_pkg::PIX_W-1:lbp_pkg::PIX_W];
  assign mid = fwd_q ? fwd_data_q[lbp_pkg::PIX_W-1:0] : rdata[lbp_pkg::PIX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.emit <= pos.emit;
      s1_item_q.last <= pos.last;
      s1_item_q.px   <= pix_i.pixel;
      s1_col_q       <= pos.col;
      fwd_q          <= s1_adv && (pos.col == s1_col_q);
      fwd_data_q     <= {mid, s1_item_q.px};
    end
  end

  lbp_window u_win (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (s1_adv),
    .item_i (s1_item_q),
    .top_i  (top),
    .mid_i  (mid),
    .room_o (room),
    .code_o (code_o)
  );

  // last code is always an interior code
  a_last_is_interior: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_item_q.last |-> s1_item_q.emit)
    else $error("last flag on a border pixel");

  // a stalled read stage keeps its request
  a_stage_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_col_q))
    else $error("read stage dropped a request");

  // every accepted pixel lands in the read stage
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> s1_valid_q)
    else $error("accepted pixel lost");

endmodule

FILE: test/tb_lbp_code_checker.sv
// Checker for the LBP code stream: watches the config port and both request
// channels, predicts every pattern code and compares it. Needs lbp_pkg, lbp_if.
module tb_lbp_code_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  lbp_pix_if                             pix_i,
  lbp_code_if                            code_i,
  output int                             mismatches_o,
  output int                             outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } pattern_t;

  logic [lbp_pkg::CFGW_W-1:0] width_reg;
  logic [lbp_pkg::CFGH_W-1:0] height_reg;
  bit   [7:0]                 one_row_up  [lbp_pkg::MAX_WIDTH];
  bit   [7:0]                 two_rows_up [lbp_pkg::MAX_WIDTH];
  logic [7:0]                 far_col  [3];  // column two left: top, mid, bottom
  logic [7:0]                 near_col [3];  // column one left; mid is the center
  logic [lbp_pkg::COL_W-1:0]  col_pos;
  logic [lbp_pkg::ROW_W-1:0]  row_pos;
  pattern_t                   pending_codes [$];
  pattern_t                   want;

  // Slides the 3x3 window by one pixel and queues the code it yields, if any.
  function automatic void predict_pattern(input logic [7:0] px, input logic sof);
    int unsigned w, h, col, row;
    logic [7:0]  top, mid, ctr;
    pattern_t    res;
    w = (width_reg < 3) ? 3 :
        ((width_reg > lbp_pkg::MAX_WIDTH) ? lbp_pkg::MAX_WIDTH : width_reg);
    h = (height_reg < 3) ? 3 :
        ((height_reg > lbp_pkg::MAX_HEIGHT) ? lbp_pkg::MAX_HEIGHT : height_reg);
    col = col_pos;
    row = row_pos;
    if (col >= w) begin
      col = 0;
      row++;
    end
    if (row >= h) row = 0;
    if (sof) begin
      col = 0;
      row = 0;
    end
    top = two_rows_up[col];
    mid = one_row_up[col];
    ctr = near_col[1];
    if (row >= 2 && col >= 2) begin
      res.code = {far_col[0] > ctr, near_col[0] > ctr, top > ctr, mid > ctr,
                  px > ctr, near_col[2] > ctr, far_col[2] > ctr, far_col[1] > ctr};
      res.last = (row == h - 1) && (col == w - 1);
      pending_codes = {pending_codes, res};
    end
    far_col = near_col;
    near_col = '{top, mid, px};
    two_rows_up[col] = mid;
    one_row_up[col] = px;
    col++;
    if (col >= w) begin
      col = 0;
      row++;
      if (row >= h) row = 0;
    end
    col_pos = col[lbp_pkg::COL_W-1:0];
    row_pos = row[lbp_pkg::ROW_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_reg = lbp_pkg::WIDTH_RESET;
      height_reg = lbp_pkg::HEIGHT_RESET;
      far_col = '{default: '0};
      near_col = '{default: '0};
      col_pos = '0;
      row_pos = '0;
      pending_codes.delete();
      mismatches_o = 0;
      outstanding_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          lbp_pkg::REG_FRAME_WIDTH:  width_reg = cfg_data_i[lbp_pkg::CFGW_W-1:0];
          lbp_pkg::REG_FRAME_HEIGHT: height_reg = cfg_data_i[lbp_pkg::CFGH_W-1:0];
          default: ;
        endcase
      end
      // a code never belongs to the pixel taken on the same edge
      if (code_i.valid && code_i.ready) begin
        if (pending_codes.size() == 0) begin
          $display("[%0t] unexpected code: expected none, got code %02h last %0b",
                   $time, code_i.lbp_code, code_i.last_code);
          mismatches_o++;
        end else begin
          want = pending_codes.pop_front();
          if (code_i.lbp_code !== want.code) begin
            $display("[%0t] lbp_code mismatch: expected %02h, got %02h",
                     $time, want.code, code_i.lbp_code);
            mismatches_o++;
          end
          if (code_i.last_code !== want.last) begin
            $display("[%0t] last_code mismatch: expected %0b, got %0b",
                     $time, want.last, code_i.last_code);
            mismatches_o++;
          end
        end
      end
      if (pix_i.valid && pix_i.ready) predict_pattern(pix_i.pixel, pix_i.start_frame);
      outstanding_o = pending_codes.size();
    end
  end

endmodule

FILE: test/tb_lbp_texture_code_stream.sv
// Testbench top for lbp_texture_code_stream: clock, reset, pixel and config
// stimulus, code sink and verdict. Needs lbp_pkg, lbp_if, tb_lbp_code_checker.
module tb_lbp_texture_code_stream;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 700;
  localparam int WIDE_ITEMS   = 1100;  // one widest row and part of the next
  localparam int DRAIN_SLACK  = 4;     // pipeline is two stages deep
  localparam int LONG_HOLD    = 200;   // sink stall that backs up the input
  localparam int IDLE_LIMIT   = 2000;  // cycles without any request moving

  logic                           clk_i;
  logic                           rst_ni;
  logic                           cfg_we;
  logic [lbp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [lbp_pkg::CFG_DATA_W-1:0] cfg_data;
  int                             mismatches;
  int                             outstanding;

  // stimulus state shared by the tasks below
  int frame_w;
  int frame_h;
  bit restart_due;   // next frame must open with a start mark
  bit no_idle;       // both sides run back to back
  bit long_hold_req; // sink takes one long stall after its next request

  lbp_pix_if  pix_if ();
  lbp_code_if code_if ();

  lbp_texture_code_stream dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if),
    .code_o     (code_if)
  );

  tb_lbp_code_checker checker_i (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data),
    .pix_i         (pix_if),
    .code_i        (code_if),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Everything is driven on the falling edge; the DUT and the checker sample
  // on the rising edge, so no sample races a drive.

  // One pixel request: optional gap with valid low, then hold until taken.
  task automatic push_pixel(input logic [7:0] px, input logic sof);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      @(negedge clk_i);
      pix_if.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    pix_if.valid <= 1'b1;
    pix_if.pixel <= px;
    pix_if.start_frame <= sof;
    do @(posedge clk_i); while (!pix_if.ready);
  endtask

  // Pixels of one frame (or a broken piece of one). Flat content keeps the
  // values in a narrow band so neighbors often tie with the center.
  // A rare start mark in mid-frame is noise that abandons the frame.
  task automatic stream_frame(input int len, input bit sof_first, input bit flat);
    logic [7:0] px;
    for (int i = 0; i < len; i++) begin
      px = flat ? 8'($urandom_range(120, 123)) : 8'($urandom);
      push_pixel(px, (i == 0) ? sof_first : ($urandom_range(0, 255) == 0));
    end
  endtask

  // Stop sending, wait for every predicted code, then let the pipe empty:
  // border pixels leave no code behind, yet may still be in flight.
  task automatic drain();
    @(negedge clk_i);
    pix_if.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (DRAIN_SLACK) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [lbp_pkg::CFG_IDX_W-1:0] idx, input int value);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= lbp_pkg::CFG_DATA_W'(value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // New frame size, written only with the block idle. If rows get wider the
  // next frame must restart, so that no line buffer column is read before
  // this frame wrote it; otherwise the frame may carry on under the new size.
  task automatic reconfigure(input int wreg, input int hreg);
    int w;
    drain();
    write_reg(lbp_pkg::REG_FRAME_WIDTH, wreg);
    write_reg(lbp_pkg::REG_FRAME_HEIGHT, hreg);
    w = (wreg < 3) ? 3 : ((wreg > lbp_pkg::MAX_WIDTH) ? lbp_pkg::MAX_WIDTH : wreg);
    restart_due = (w > frame_w) || ($urandom_range(0, 1) == 1);
    frame_w = w;
    frame_h = (hreg < 3) ? 3 : ((hreg > lbp_pkg::MAX_HEIGHT) ? lbp_pkg::MAX_HEIGHT : hreg);
  endtask

  // Code sink: random stall per request, one long stall on demand.
  initial begin : code_sink
    int stall;
    code_if.ready = 1'b0;
    forever begin
      if (long_hold_req) begin
        stall = LONG_HOLD;
        long_hold_req = 1'b0;
      end else begin
        stall = no_idle ? 0 : $urandom_range(0, 9);
      end
      if (stall > 0) begin
        @(negedge clk_i);
        code_if.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk_i);
      end
      @(negedge clk_i);
      code_if.ready <= 1'b1;
      do @(posedge clk_i); while (!code_if.valid);
    end
  end

  // Watchdog: ends the run when no request moves on either side for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      if ((pix_if.valid && pix_if.ready) || (code_if.valid && code_if.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("[lbp_texture_code_stream] ERROR");
    $finish;
  end

  initial begin : stimulus
    logic [7:0] opening [22];
    int         random_items;
    int         wreg, hreg, len;
    bit         sof, broken;

    pix_if.valid = 1'b0;
    pix_if.pixel = '0;
    pix_if.start_frame = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = lbp_pkg::REG_FRAME_WIDTH;
    cfg_data = '0;
    no_idle = 1'b0;
    long_hold_req = 1'b0;
    restart_due = 1'b1;
    random_items = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Opening frames at the smallest size, both registers below range so
    // they clamp to 3x3.
    //  - all neighbors brightest around a black center: every bit set
    //  - a second frame with no start mark (the position wraps by itself);
    //    the top neighbor ties with the center, which must leave its bit
    //    clear, and the others give a code with no symmetry to hide a
    //    swapped bit
    //  - a third frame left unfinished: its first row and one more pixel
    opening = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd0,   8'd255, 8'd255, 8'd255, 8'd255,
                8'd0,   8'd128, 8'd255, 8'd200, 8'd128, 8'd50,  8'd255, 8'd127, 8'd129,
                8'd1,   8'd2,   8'd4,   8'd8};
    write_reg(lbp_pkg::REG_FRAME_WIDTH, 0);
    write_reg(lbp_pkg::REG_FRAME_HEIGHT, 1);
    frame_w = 3;
    frame_h = 3;
    for (int i = 0; i < 22; i++) push_pixel(opening[i], i == 0);

    // Widest rows (width above range clamps to the maximum), back to back:
    // one full row and part of the next, so the row wraps at the last column.
    reconfigure(2047, 2);
    no_idle = 1'b1;
    stream_frame(WIDE_ITEMS, 1'b1, 1'b0);
    no_idle = 1'b0;

    // Exact maximum width with a height above range: a few pixels only.
    reconfigure(1024, 8191);
    stream_frame(40, restart_due, 1'b0);
    // Narrowest rows at the exact maximum height, possibly carrying on from
    // the wide frame, whose column position then lies past the new width.
    // Back to back; the sink stalls for a long stretch once codes start, so
    // the block fills up and pushes back on the pixel side.
    reconfigure(0, 4096);
    no_idle = 1'b1;
    long_hold_req = 1'b1;
    stream_frame(60, restart_due, 1'b1);
    no_idle = 1'b0;

    // Random phases: small frames, mostly whole and well formed, some
    // broken off early, some continued across a size change.
    while (random_items < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0:       wreg = $urandom_range(0, 2);
        1:       wreg = $urandom_range(11, 24);
        default: wreg = $urandom_range(3, 8);
      endcase
      hreg = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 6);
      reconfigure(wreg, hreg);
      no_idle = ($urandom_range(0, 3) == 0);
      sof = restart_due;
      repeat ($urandom_range(1, 3)) begin
        len = frame_w * frame_h;
        broken = ($urandom_range(0, 7) == 0);
        if (broken) len = $urandom_range(1, len - 1);
        stream_frame(len, sof, $urandom_range(0, 2) == 0);
        random_items += len;
        sof = broken || ($urandom_range(0, 1) == 1);
      end
    end
    no_idle = 1'b0;

    drain();
    if (mismatches == 0)
      $display("[lbp_texture_code_stream] OK");
    else
      $display("[lbp_texture_code_stream] ERROR");
    $finish;
  end

endmodule

FILE: lbp_texture_code_stream.f
hw/rtl/lbp_pkg.sv
hw/rtl/lbp_if.sv
hw/rtl/lbp_line_ram.sv
hw/rtl/lbp_position.sv
hw/rtl/lbp_window.sv
hw/rtl/lbp_texture_code_stream.sv
test/tb_lbp_code_checker.sv
test/tb_lbp_texture_code_stream.sv
